// File: sv/gdad_pkg.sv
// gdad_pkg: shared types, constants and calendar functions for the date adder
// used by gdad_ctrl, gdad_datapath and the top level; no dependencies

package gdad_pkg;

	// calendar constants
	localparam logic [13:0] YEAR_LIMIT   = 14'd16383;
	localparam logic [13:0] DEFAULT_YEAR = 14'd2000;
	localparam logic [3:0]  MONTH_JAN    = 4'd1;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [3:0]  MONTH_APR    = 4'd4;
	localparam logic [3:0]  MONTH_JUN    = 4'd6;
	localparam logic [3:0]  MONTH_SEP    = 4'd9;
	localparam logic [3:0]  MONTH_NOV    = 4'd11;
	localparam logic [3:0]  MONTH_DEC    = 4'd12;
	localparam logic [4:0]  LEN_LONG     = 5'd31;
	localparam logic [4:0]  LEN_SHORT    = 5'd30;
	localparam logic [4:0]  LEN_FEB_LEAP = 5'd29;
	localparam logic [4:0]  LEN_FEB      = 5'd28;

	// divisibility by 25 on a 14-bit year: multiply by the inverse of 25
	// modulo 2^14, multiples of 25 land on 0 .. 16383/25
	localparam logic [13:0] INV25        = 14'd7209;
	localparam logic [13:0] DIV25_LIMIT  = 14'd655;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture a new input transfer
		logic leap_upd;   // recompute the leap flag of the working year
		logic check;      // validate start date and add the day count
		logic walk_step;  // subtract one month length, advance the month
		logic saturate;   // clamp to the last day of the maximum year
		logic doy_init;   // start the day-of-year sum
		logic doy_step;   // add one preceding month length
		logic out_load;   // copy the result into the output register
	} gdad_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic day_over;   // day count still exceeds the month length
		logic at_limit;   // December of the maximum year
		logic month_dec;  // working month is December
		logic idx_below;  // day-of-year index has not reached the month
	} gdad_status_t;

	// gregorian leap rule
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] prod;
		logic        div25;
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIMIT);
		return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
	endfunction

	// days in a month; codes outside 1..12 give the long length
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? LEN_FEB_LEAP : LEN_FEB;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
				m == MONTH_NOV) begin
			len = LEN_SHORT;
		end else begin
			len = LEN_LONG;
		end
		return len;
	endfunction

endpackage

// File: sv/gdad_datapath.sv
// gdad_datapath: working date registers, month walk arithmetic and output register
// depends on gdad_pkg; driven by gdad_ctrl through gdad_cmd_t

module gdad_datapath #(
	parameter int ADD_DAYS_BITS = 12
) (
	input  logic                     clk,
	input  gdad_pkg::gdad_cmd_t      cmd,
	output gdad_pkg::gdad_status_t   status,
	input  logic [3:0]               month_in,
	input  logic [4:0]               day_in,
	input  logic [13:0]              year_in,
	input  logic [ADD_DAYS_BITS-1:0] add_days,
	output logic [3:0]               month_out,
	output logic [4:0]               day_out,
	output logic [13:0]              year_out,
	output logic [8:0]               day_of_year,
	output logic                     input_valid,
	output logic                     year_overflow
);

	// running day count holds a day of month plus the whole count
	localparam int DAY_W = ((ADD_DAYS_BITS > 5) ? ADD_DAYS_BITS : 5) + 1;

	logic [3:0]               month_q;
	logic [DAY_W-1:0]         day_q;
	logic [13:0]              year_q;
	logic [ADD_DAYS_BITS-1:0] count_q;
	logic                     leap_q;
	logic                     valid_q;
	logic                     over_q;
	logic [8:0]               doy_q;
	logic [3:0]               idx_q;

	logic [4:0] len_cur;
	logic [4:0] len_idx;
	logic       date_bad;

	// month lengths for the working month and the day-of-year index
	assign len_cur = gdad_pkg::month_len(month_q, leap_q);
	assign len_idx = gdad_pkg::month_len(idx_q, leap_q);

	// start date validity
	assign date_bad = (month_q == 4'd0) || (month_q > gdad_pkg::MONTH_DEC) ||
		(year_q == 14'd0) || (day_q == '0) || (day_q > DAY_W'(len_cur));

	// status back to the controller
	assign status.day_over  = day_q > DAY_W'(len_cur);
	assign status.at_limit  = (month_q == gdad_pkg::MONTH_DEC) &&
		(year_q == gdad_pkg::YEAR_LIMIT);
	assign status.month_dec = month_q == gdad_pkg::MONTH_DEC;
	assign status.idx_below = idx_q < month_q;

	// working registers
	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			month_q <= month_in;
			day_q   <= DAY_W'(day_in);
			year_q  <= year_in;
			count_q <= add_days;
			over_q  <= 1'b0;
		end else if (cmd.leap_upd) begin
			leap_q <= gdad_pkg::is_leap(year_q);
		end else if (cmd.check) begin
			if (date_bad) begin
				month_q <= gdad_pkg::MONTH_JAN;
				day_q   <= DAY_W'(1) + DAY_W'(count_q);
				year_q  <= gdad_pkg::DEFAULT_YEAR;
				leap_q  <= 1'b1;
				valid_q <= 1'b0;
			end else begin
				day_q   <= day_q + DAY_W'(count_q);
				valid_q <= 1'b1;
			end
		end else if (cmd.walk_step) begin
			day_q <= day_q - DAY_W'(len_cur);
			if (month_q == gdad_pkg::MONTH_DEC) begin
				month_q <= gdad_pkg::MONTH_JAN;
				year_q  <= year_q + 14'd1;
			end else begin
				month_q <= month_q + 4'd1;
			end
		end else if (cmd.saturate) begin
			month_q <= gdad_pkg::MONTH_DEC;
			day_q   <= DAY_W'(gdad_pkg::LEN_LONG);
			year_q  <= gdad_pkg::YEAR_LIMIT;
			over_q  <= 1'b1;
		end else if (cmd.doy_init) begin
			doy_q <= 9'(day_q);
			idx_q <= gdad_pkg::MONTH_JAN;
		end else if (cmd.doy_step) begin
			doy_q <= doy_q + 9'(len_idx);
			idx_q <= idx_q + 4'd1;
		end
	end

	// output register, held until the result transfer
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			month_out     <= month_q;
			day_out       <= day_q[4:0];
			year_out      <= year_q;
			day_of_year   <= doy_q;
			input_valid   <= valid_q;
			year_overflow <= over_q;
		end
	end

endmodule

// File: sv/gdad_ctrl.sv
// gdad_ctrl: sequencer for the date adder, drives the handshakes and datapath commands
// depends on gdad_pkg; pairs with gdad_datapath

module gdad_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  gdad_pkg::gdad_status_t status,
	output gdad_pkg::gdad_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LEAP_IN = 7'b0000010,
		S_CHECK   = 7'b0000100,
		S_WALK    = 7'b0001000,
		S_LEAP    = 7'b0010000,
		S_DOY     = 7'b0100000,
		S_FINISH  = 7'b1000000
	} gdad_state_t;

	gdad_state_t state_q;
	gdad_state_t state_d;
	logic        out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LEAP_IN;
				end
			end
			S_LEAP_IN: begin
				cmd.leap_upd = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_WALK;
			end
			S_WALK: begin
				if (status.day_over) begin
					if (status.at_limit) begin
						cmd.saturate = 1'b1;
					end else begin
						cmd.walk_step = 1'b1;
						if (status.month_dec) begin
							state_d = S_LEAP;
						end
					end
				end else begin
					cmd.doy_init = 1'b1;
					state_d      = S_DOY;
				end
			end
			S_LEAP: begin
				cmd.leap_upd = 1'b1;
				state_d      = S_WALK;
			end
			S_DOY: begin
				if (status.idx_below) begin
					cmd.doy_step = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/gregorian_date_add_days_top.sv
// gregorian_date_add_days_top: after an input transfer the sequencer updates the leap
// flag, checks the start date and adds the count, then walks month by month (a leap
// update at each year boundary, a saturate step at the limit), sums the preceding months
// into the day of year and loads the output register once a stalled result has left it;
// one item at a time, the next input taken while the result waits in the output register
// arst_n clears the sequencer and result valid; payload registers are not reset

module gregorian_date_add_days_top #(
	parameter int ADD_DAYS_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               month_in,
	input  logic [4:0]               day_in,
	input  logic [13:0]              year_in,
	input  logic [ADD_DAYS_BITS-1:0] add_days,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [3:0]               month_out,
	output logic [4:0]               day_out,
	output logic [13:0]              year_out,
	output logic [8:0]               day_of_year,
	output logic                     input_valid,
	output logic                     year_overflow
);

	gdad_pkg::gdad_cmd_t    cmd;
	gdad_pkg::gdad_status_t status;

	// sequencer
	gdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// date arithmetic
	gdad_datapath #(
		.ADD_DAYS_BITS (ADD_DAYS_BITS)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.month_in      (month_in),
		.day_in        (day_in),
		.year_in       (year_in),
		.add_days      (add_days),
		.month_out     (month_out),
		.day_out       (day_out),
		.year_out      (year_out),
		.day_of_year   (day_of_year),
		.input_valid   (input_valid),
		.year_overflow (year_overflow)
	);

endmodule

// File: sv/gdad_checker.sv
// gdad_props: port-level checks on the result channel of the date adder
// bound to gregorian_date_add_days_top; no package dependency

module gdad_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out,
	input logic [13:0] year_out,
	input logic [8:0]  day_of_year
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(month_out) &&
		$stable(day_out) && $stable(year_out) && $stable(day_of_year))
		else $error("result changed while stalled");

	// result month, year and ordinal day lie in calendar range and the day is at least 1
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 &&
		year_out >= 14'd1 && day_of_year >= 9'd1 && day_of_year <= 9'd366)
		else $error("result date out of range");

	// in january the ordinal day equals the day of month
	a_jan_doy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && month_out == 4'd1 |-> day_of_year == 9'(day_out))
		else $error("january day of year mismatch");

	// ordinal day never falls below the day of month
	a_doy_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> day_of_year >= 9'(day_out))
		else $error("day of year below day of month");

endmodule

bind gregorian_date_add_days_top gdad_props u_gdad_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.month_out   (month_out),
	.day_out     (day_out),
	.year_out    (year_out),
	.day_of_year (day_of_year)
);

// File: sim/gdad_checker.sv
// gdad_checker: watches both channels of the date adder, predicts each result
// and compares it field by field; depends on gdad_pkg for the calendar constants

module gdad_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [13:0] year_in,
	input  logic [11:0] add_days,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  month_out,
	input  logic [4:0]  day_out,
	input  logic [13:0] year_out,
	input  logic [8:0]  day_of_year,
	input  logic        input_valid,
	input  logic        year_overflow,
	output int          outstanding,
	output int          mismatches
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [8:0]  doy;
		logic        valid;
		logic        over;
	} date_res_t;

	date_res_t expected_dates[$];

	// gregorian leap rule, written with plain remainders
	function automatic bit leap_yr(int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int days_in_month(int m, int y);
		int len;
		if (m == int'(gdad_pkg::MONTH_FEB)) begin
			len = leap_yr(y) ? int'(gdad_pkg::LEN_FEB_LEAP) : int'(gdad_pkg::LEN_FEB);
		end else if (m == int'(gdad_pkg::MONTH_APR) || m == int'(gdad_pkg::MONTH_JUN) ||
				m == int'(gdad_pkg::MONTH_SEP) || m == int'(gdad_pkg::MONTH_NOV)) begin
			len = int'(gdad_pkg::LEN_SHORT);
		end else begin
			len = int'(gdad_pkg::LEN_LONG);
		end
		return len;
	endfunction

	// start date checked, count added month by month, then ordinal day summed
	function automatic date_res_t add_to_date(logic [3:0] m_in, logic [4:0] d_in,
			logic [13:0] y_in, logic [11:0] n_in);
		int m;
		int d;
		int y;
		int doy;
		date_res_t res;
		m = int'(m_in);
		d = int'(d_in);
		y = int'(y_in);
		res.valid = 1'b1;
		res.over = 1'b0;
		if (m < 1 || m > 12 || y < 1 || d < 1 || d > days_in_month(m, y)) begin
			res.valid = 1'b0;
			m = int'(gdad_pkg::MONTH_JAN);
			d = 1;
			y = int'(gdad_pkg::DEFAULT_YEAR);
		end
		d = d + int'(n_in);
		while (d > days_in_month(m, y)) begin
			if (m == int'(gdad_pkg::MONTH_DEC) && y >= int'(gdad_pkg::YEAR_LIMIT)) begin
				m = int'(gdad_pkg::MONTH_DEC);
				d = int'(gdad_pkg::LEN_LONG);
				y = int'(gdad_pkg::YEAR_LIMIT);
				res.over = 1'b1;
				break;
			end
			d = d - days_in_month(m, y);
			if (m == int'(gdad_pkg::MONTH_DEC)) begin
				m = int'(gdad_pkg::MONTH_JAN);
				y = y + 1;
			end else begin
				m = m + 1;
			end
		end
		doy = d;
		for (int i = 1; i < m; i++) begin
			doy = doy + days_in_month(i, y);
		end
		res.month = 4'(m);
		res.day = 5'(d);
		res.year = 14'(y);
		res.doy = 9'(doy);
		return res;
	endfunction

	task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// result side first: a result can never belong to an input taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		date_res_t exp_res;
		if (!arst_n) begin
			outstanding <= 0;
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$error("result transfer with no outstanding input");
					mismatches++;
				end else begin
					exp_res = expected_dates.pop_front();
					compare_field("month_out", 16'(exp_res.month), 16'(month_out));
					compare_field("day_out", 16'(exp_res.day), 16'(day_out));
					compare_field("year_out", 16'(exp_res.year), 16'(year_out));
					compare_field("day_of_year", 16'(exp_res.doy), 16'(day_of_year));
					compare_field("input_valid", 16'(exp_res.valid), 16'(input_valid));
					compare_field("year_overflow", 16'(exp_res.over), 16'(year_overflow));
				end
			end
			if (in_valid && in_ready) begin
				expected_dates.push_back(add_to_date(month_in, day_in, year_in, add_days));
			end
			outstanding <= expected_dates.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// tb_top: clock, reset, directed and random date transfers with random idling
// for gregorian_date_add_days_top; depends on gdad_pkg and gdad_checker

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [13:0] year_in;
	logic [11:0] add_days;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [13:0] year_out;
	logic [8:0]  day_of_year;
	logic        input_valid;
	logic        year_overflow;
	int          outstanding;
	int          mismatches;
	bit          send_burst;
	bit          drain_burst;

	gregorian_date_add_days_top #(
		.ADD_DAYS_BITS(12)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.month_in(month_in),
		.day_in(day_in),
		.year_in(year_in),
		.add_days(add_days),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.month_out(month_out),
		.day_out(day_out),
		.year_out(year_out),
		.day_of_year(day_of_year),
		.input_valid(input_valid),
		.year_overflow(year_overflow)
	);

	gdad_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.month_in(month_in),
		.day_in(day_in),
		.year_in(year_in),
		.add_days(add_days),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.month_out(month_out),
		.day_out(day_out),
		.year_out(year_out),
		.day_of_year(day_of_year),
		.input_valid(input_valid),
		.year_overflow(year_overflow),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_cycles(bit burst);
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (burst || r < 55) begin
			len = 0;
		end else if (r < 88) begin
			len = $urandom_range(1, 3);
		end else if (r < 97) begin
			len = $urandom_range(4, 12);
		end else begin
			len = $urandom_range(20, 60);
		end
		return len;
	endfunction

	// one input transfer, valid held until accepted
	task automatic send_date(logic [3:0] m, logic [4:0] d, logic [13:0] y, logic [11:0] n);
		@(negedge clk);
		in_valid <= 1'b1;
		month_in <= m;
		day_in <= d;
		year_in <= y;
		add_days <= n;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic sender_gap(int len);
		if (len > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (len - 1) @(negedge clk);
		end
	endtask

	// mostly well-formed dates with random content, the rest raw noise
	task automatic send_random_date();
		logic [3:0]  m;
		logic [4:0]  d;
		logic [13:0] y;
		logic [11:0] n;
		int          ysel;
		if ($urandom_range(0, 99) < 80) begin
			m = 4'($urandom_range(1, 12));
			d = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 28) :
				$urandom_range(29, 31));
			ysel = $urandom_range(0, 9);
			if (ysel == 0) begin
				y = 14'($urandom_range(16365, 16383));
			end else if (ysel == 1) begin
				y = 14'($urandom_range(1, 20));
			end else if (ysel == 2) begin
				y = 14'($urandom_range(1, 163) * 100);
			end else begin
				y = 14'($urandom_range(1, 16383));
			end
			n = 12'(($urandom_range(0, 9) < 7) ? $urandom : $urandom_range(0, 40));
		end else begin
			m = 4'($urandom);
			d = 5'($urandom);
			y = 14'($urandom);
			n = 12'($urandom);
		end
		send_date(m, d, y, n);
	endtask

	// run limit
	initial begin
		#60_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls, with stall-free stretches
	initial begin
		out_ready = 1'b0;
		drain_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			if ($urandom_range(0, 99) < 3) begin
				drain_burst = !drain_burst;
			end
			repeat (idle_cycles(drain_burst)) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		month_in = '0;
		day_in = '0;
		year_in = '0;
		add_days = '0;
		send_burst = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, leap rules, invalid dates and saturation
		send_date(4'd1, 5'd1, 14'd1, 12'd0);
		send_date(4'd12, 5'd31, 14'd16383, 12'd0);
		send_date(4'd12, 5'd31, 14'd16383, 12'd1);
		send_date(4'd6, 5'd15, 14'd16375, 12'd4095);
		send_date(4'd1, 5'd1, 14'd16383, 12'd364);
		send_date(4'd1, 5'd1, 14'd16383, 12'd365);
		sender_gap(5);
		send_date(4'd2, 5'd29, 14'd2000, 12'd1);
		send_date(4'd2, 5'd29, 14'd1900, 12'd0);
		send_date(4'd2, 5'd29, 14'd2024, 12'd365);
		send_date(4'd2, 5'd29, 14'd2023, 12'd0);
		send_date(4'd2, 5'd28, 14'd2023, 12'd1);
		send_date(4'd2, 5'd29, 14'd2100, 12'd0);
		send_date(4'd2, 5'd29, 14'd2400, 12'd4095);
		send_date(4'd4, 5'd31, 14'd2021, 12'd0);
		send_date(4'd0, 5'd10, 14'd2021, 12'd5);
		send_date(4'd15, 5'd31, 14'd16383, 12'd4095);
		send_date(4'd13, 5'd1, 14'd2021, 12'd0);
		send_date(4'd5, 5'd0, 14'd2021, 12'd10);
		send_date(4'd7, 5'd4, 14'd0, 12'd100);
		send_date(4'd1, 5'd31, 14'd1, 12'd4095);
		send_date(4'd12, 5'd31, 14'd1999, 12'd1);
		send_date(4'd10, 5'd31, 14'd9999, 12'd0);
		send_date(4'd11, 5'd30, 14'd8191, 12'd61);

		// random part
		for (int i = 0; i < 1600; i++) begin
			sender_gap(idle_cycles(send_burst));
			send_random_date();
			if (i % 150 == 149 && $urandom_range(0, 2) == 0) begin
				send_burst = !send_burst;
			end
			// hold off until the block has drained completely
			if (i == 800) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (outstanding == 0);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then allow for a stray late result
		wait (outstanding == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/gdad_pkg.sv
sv/gdad_datapath.sv
sv/gdad_ctrl.sv
sv/gregorian_date_add_days_top.sv
sv/gdad_checker.sv
sim/gdad_checker.sv
sim/tb_top.sv
